/* hw/rtl/complex_pair_40bit_packer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the complex pair 40-bit packer
// Concurrent checks are active in simulation and compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_PAIR_40BIT_PACKER_ASSERT_SVH
`define COMPLEX_PAIR_40BIT_PACKER_ASSERT_SVH

`ifndef SYNTHESIS

// Implication in the same cycle.
`define CP40_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cp40 assertion failed");

// Implication in the following cycle.
`define CP40_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cp40 assertion failed");

`else

`define CP40_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define CP40_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hw/rtl/cp40_pkg.sv */
// ----------------------------------------------------------------------------
// cp40_pkg
// Shared types and constants for the complex pair 40-bit packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cp40_pkg;

  localparam int unsigned MantW     = 23;  // IEEE single fraction width
  localparam int unsigned PackW     = 17;  // packed mantissa incl. flag
  localparam int unsigned BaseShift = 6;
  localparam int unsigned MaxShift  = 23;
  localparam int unsigned MaxExp    = 15;

  typedef logic [MantW-1:0] mant_t;
  typedef logic [4:0]       shift_t;   // 0..23
  typedef logic [PackW-1:0] pack_t;

endpackage

`default_nettype wire

/* hw/rtl/cp40_mant_pack.sv */
// ----------------------------------------------------------------------------
// cp40_mant_pack
// Shifts one mantissa, rounds it up by one unless the field is zero or all ones, and inserts the hidden-one flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cp40_mant_pack (
  input  cp40_pkg::mant_t  mant_i,
  input  cp40_pkg::shift_t shift_i,   // 6..23
  output cp40_pkg::pack_t  pack_o
);

  logic [cp40_pkg::PackW:0] shifted;
  logic [cp40_pkg::PackW:0] ones;
  logic [cp40_pkg::PackW:0] rounded;
  logic [cp40_pkg::PackW:0] flag;
  logic [cp40_pkg::PackW:0] merged;
  logic                     bump;
  cp40_pkg::shift_t         flag_pos;

  assign shifted  = (cp40_pkg::PackW + 1)'(mant_i >> shift_i);
  assign ones     = (cp40_pkg::PackW + 1)'({cp40_pkg::MantW{1'b1}} >> shift_i);
  // No increment for zero or an all-ones field.
  assign bump     = (shifted != '0) && (shifted != ones);
  assign rounded  = shifted + (cp40_pkg::PackW + 1)'(bump);
  assign flag_pos = 5'(cp40_pkg::MaxShift) - shift_i;
  assign flag     = (cp40_pkg::PackW + 1)'(1) << flag_pos;
  assign merged   = rounded | flag;
  assign pack_o   = merged[cp40_pkg::PackW:1];

endmodule

`default_nettype wire

/* hw/rtl/complex_pair_40bit_packer.sv */
// ----------------------------------------------------------------------------
// complex_pair_40bit_packer
// Packs a complex float pair into a 40-bit shared-exponent code.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat carries a complex value, real part IEEE single in
//   tdata[31:0], imaginary part in tdata[63:32].
//   Master stream: one beat per input beat, tdata[7:0] header byte,
//   tdata[23:8] real mantissa low word, tdata[39:24] imaginary low word.
//   Config: cfg_we_i writes cfg_wdata_i into the exponent bias (reset 138);
//   write it only while no beat is in flight.
// Timing:
//   An input beat lands in an input register, the packing logic sits between
//   that register and the output register. m_axis_tvalid rises once the beat
//   moves from the input register into the output register; throughput is
//   one beat per cycle while the receiver keeps tready high, set by the
//   two-register pipeline with no iterative unit.
// Reset and stalls:
//   Reset empties both registers and restores the bias. When the receiver
//   holds tready low the output beat holds, the input register can still
//   take one more beat, then s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "complex_pair_40bit_packer_assert.svh"

module complex_pair_40bit_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,     // exponent_bias
  // slave side
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,    // [31:0] real_bits, [63:32] imag_bits
  // master side
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata     // [7:0] header_byte,
                                            // [23:8] real_mantissa_low,
                                            // [39:24] imag_mantissa_low
);

  // Bias register
  logic [7:0] bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= 8'd138;
    end else if (cfg_we_i) begin
      bias_q <= cfg_wdata_i;
    end
  end

  // Pipeline control
  logic        in_valid_q, in_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic        in_fire;
  logic [31:0] real_q, imag_q;
  logic [39:0] out_data_q, out_data_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      real_q <= s_axis_tdata[31:0];
      imag_q <= s_axis_tdata[63:32];
    end
    if (advance && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  // Exponent alignment. Biased exponents minus bias span -255..255.
  logic signed [10:0] exp_r, exp_i, exp_max, exp_sh;
  logic signed [10:0] gap_r, gap_i;
  logic               ovf;
  cp40_pkg::shift_t   sh_r, sh_i;
  cp40_pkg::pack_t    pk_r, pk_i;
  logic [16:0]        m_r, m_i;
  logic [3:0]         exp_out;

  localparam logic signed [10:0] GapLimit =
    11'(cp40_pkg::MaxShift - cp40_pkg::BaseShift);

  always_comb begin
    exp_r   = $signed({3'b000, real_q[30:23]}) - $signed({3'b000, bias_q});
    exp_i   = $signed({3'b000, imag_q[30:23]}) - $signed({3'b000, bias_q});
    exp_max = (exp_r > exp_i) ? exp_r : exp_i;
    // Negative shared exponent clamps to zero; its magnitude lands in both shifts.
    exp_sh  = (exp_max < 0) ? 11'sd0 : exp_max;
    gap_r   = exp_sh - exp_r;   // 0..255
    gap_i   = exp_sh - exp_i;
    sh_r    = (gap_r > GapLimit) ? 5'(cp40_pkg::MaxShift)
                                 : 5'(gap_r[4:0] + 5'(cp40_pkg::BaseShift));
    sh_i    = (gap_i > GapLimit) ? 5'(cp40_pkg::MaxShift)
                                 : 5'(gap_i[4:0] + 5'(cp40_pkg::BaseShift));
  end

  cp40_mant_pack u_pack_re (
    .mant_i  (real_q[22:0]),
    .shift_i (sh_r),
    .pack_o  (pk_r)
  );

  cp40_mant_pack u_pack_im (
    .mant_i  (imag_q[22:0]),
    .shift_i (sh_i),
    .pack_o  (pk_i)
  );

  // Exponent overflow saturates both mantissas to 0xFFFF.
  always_comb begin
    ovf     = exp_sh > 11'(cp40_pkg::MaxExp);
    m_r     = ovf ? 17'h0FFFF : pk_r;
    m_i     = ovf ? 17'h0FFFF : pk_i;
    exp_out = ovf ? 4'(cp40_pkg::MaxExp) : exp_sh[3:0];
    out_data_d = {m_i[15:0], m_r[15:0],
                  real_q[31], imag_q[31], m_r[16], m_i[16], exp_out};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `CP40_ASSERT_NEXT(a_held_in_stage, clk_i, rst_ni, in_valid_q && !advance, in_valid_q)
  `CP40_ASSERT_NOW(a_full_blocks, clk_i, rst_ni, in_valid_q && out_valid_q && !m_axis_tready,
                   !s_axis_tready)
  `CP40_ASSERT_NEXT(a_drain, clk_i, rst_ni, out_valid_q && m_axis_tready && !in_valid_q,
                    !out_valid_q)

endmodule

`default_nettype wire
